>>> sv/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg: shared types and constants for the format specifier parser
// Holds the character codes, the length and sign codes, the parse phase
// encoding and the structures passed between the top level and the step logic.
// ----------------------------------------------------------------------------
package spf_pkg;

   // Default accumulator width for width and precision.
   localparam int SPF_COUNT_BITS = 16;

   // Output field widths, fixed by the interface.
   localparam int CHAR_BITS  = 8;
   localparam int NUM_BITS   = 16;
   localparam int SIGN_BITS  = 2;
   localparam int SIZE_BITS  = 3;
   localparam int DIGIT_BITS = 4;

   // Character codes.
   localparam logic [CHAR_BITS-1:0] CH_PERCENT = 8'h25;
   localparam logic [CHAR_BITS-1:0] CH_HASH    = 8'h23;
   localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_DOT     = 8'h2E;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_H = 8'h68;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_L = 8'h6C;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_L = 8'h4C;

   // Sign mode codes.
   localparam logic [SIGN_BITS-1:0] SIGN_NONE  = 2'd0;
   localparam logic [SIGN_BITS-1:0] SIGN_PLUS  = 2'd1;
   localparam logic [SIGN_BITS-1:0] SIGN_SPACE = 2'd2;

   // Integer size codes.
   localparam logic [SIZE_BITS-1:0] SIZE_NONE = 3'd0;
   localparam logic [SIZE_BITS-1:0] SIZE_HH   = 3'd1;
   localparam logic [SIZE_BITS-1:0] SIZE_H    = 3'd2;
   localparam logic [SIZE_BITS-1:0] SIZE_L    = 3'd3;
   localparam logic [SIZE_BITS-1:0] SIZE_LL   = 3'd4;

   // Parse phase, one-hot.
   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_FLAGS   = 7'b0000010,
      PH_WIDTH   = 7'b0000100,
      PH_PREC    = 7'b0001000,
      PH_MOD_H   = 7'b0010000,
      PH_MOD_L   = 7'b0100000,
      PH_MOD_END = 7'b1000000
   } phase_type;

   // Flags collected while a specifier is parsed.
   typedef struct packed {
      logic                 alt_seen;
      logic                 left_seen;
      logic [SIGN_BITS-1:0] sign_kind;
      logic                 zero_seen;
      logic                 width_flag;
      logic                 prec_flag;
      logic [SIZE_BITS-1:0] size_code;
   } flags_type;

   localparam flags_type FLAGS_CLEAR = '{
      alt_seen:   1'b0,
      left_seen:  1'b0,
      sign_kind:  SIGN_NONE,
      zero_seen:  1'b0,
      width_flag: 1'b0,
      prec_flag:  1'b0,
      size_code:  SIZE_NONE
   };

   // One completed specifier.
   typedef struct packed {
      logic                 alt_form;
      logic                 left_adjust;
      logic [SIGN_BITS-1:0] sign_mode;
      logic                 zero_pad;
      logic [NUM_BITS-1:0]  width;
      logic                 width_given;
      logic [NUM_BITS-1:0]  precision;
      logic                 precision_given;
      logic [SIZE_BITS-1:0] int_size;
      logic [CHAR_BITS-1:0] conv_char;
   } result_type;

endpackage

>>> sv/spf_step.sv
// ----------------------------------------------------------------------------
// spf_step: next-state logic of the format specifier parser
// Takes the current parse state and one character and gives the next state,
// plus a result when the character ends a specifier.
// ----------------------------------------------------------------------------
module spf_step
   import spf_pkg::*;
#(
   parameter int COUNT_BITS = SPF_COUNT_BITS
) (
   input  phase_type              phase,
   input  flags_type              flags,
   input  logic [COUNT_BITS-1:0]  width_acc,
   input  logic [COUNT_BITS-1:0]  prec_acc,
   input  logic [CHAR_BITS-1:0]   ch,
   output phase_type              phase_next,
   output flags_type              flags_next,
   output logic [COUNT_BITS-1:0]  width_acc_next,
   output logic [COUNT_BITS-1:0]  prec_acc_next,
   output logic                   emit,
   output result_type             result
);

   localparam int WIDE_BITS = COUNT_BITS + DIGIT_BITS;

   logic                  is_digit;
   logic [DIGIT_BITS-1:0] digit;
   logic [COUNT_BITS-1:0] acc_sel;
   logic [WIDE_BITS-1:0]  acc_wide;
   logic [WIDE_BITS-1:0]  acc_scaled;
   logic [COUNT_BITS-1:0] acc_new;
   logic                  try_mod;
   logic [SIZE_BITS-1:0]  size_emit;

   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign digit    = DIGIT_BITS'(ch - CH_ZERO);

   // One shared multiply-by-ten accumulator; only one number grows at a time.
   assign acc_sel    = (phase == PH_PREC) ? prec_acc : width_acc;
   assign acc_wide   = WIDE_BITS'(acc_sel);
   assign acc_scaled = (acc_wide << 3) + (acc_wide << 1) + WIDE_BITS'(digit);
   assign acc_new    = (|acc_scaled[WIDE_BITS-1:COUNT_BITS]) ? '1
                                                             : acc_scaled[COUNT_BITS-1:0];

   // Phase transitions and field updates.
   always_comb begin
      phase_next     = phase;
      flags_next     = flags;
      width_acc_next = width_acc;
      prec_acc_next  = prec_acc;
      emit           = 1'b0;
      try_mod        = 1'b0;
      size_emit      = flags.size_code;

      unique case (phase)
         PH_IDLE: begin
            if (ch == CH_PERCENT) begin
               flags_next     = FLAGS_CLEAR;
               width_acc_next = '0;
               prec_acc_next  = '0;
               phase_next     = PH_FLAGS;
            end
         end
         PH_FLAGS: begin
            if (ch == CH_HASH) begin
               flags_next.alt_seen = 1'b1;
            end else if (ch == CH_MINUS) begin
               flags_next.left_seen = 1'b1;
            end else if (ch == CH_PLUS) begin
               flags_next.sign_kind = SIGN_PLUS;
            end else if (ch == CH_SPACE) begin
               if (flags.sign_kind == SIGN_NONE) begin
                  flags_next.sign_kind = SIGN_SPACE;
               end
            end else if ((ch == CH_ZERO) && !flags.left_seen) begin
               flags_next.zero_seen = 1'b1;
            end else if (is_digit) begin
               width_acc_next        = acc_new;
               flags_next.width_flag = 1'b1;
               phase_next            = PH_WIDTH;
            end else if (ch == CH_DOT) begin
               flags_next.prec_flag = 1'b1;
               prec_acc_next        = '0;
               phase_next           = PH_PREC;
            end else begin
               try_mod = 1'b1;
            end
         end
         PH_WIDTH: begin
            if (is_digit) begin
               width_acc_next = acc_new;
            end else if (ch == CH_DOT) begin
               flags_next.prec_flag = 1'b1;
               prec_acc_next        = '0;
               phase_next           = PH_PREC;
            end else begin
               try_mod = 1'b1;
            end
         end
         PH_PREC: begin
            if (is_digit) begin
               prec_acc_next = acc_new;
            end else begin
               try_mod = 1'b1;
            end
         end
         PH_MOD_H: begin
            if (ch == CH_LOWER_H) begin
               flags_next.size_code = SIZE_HH;
               phase_next           = PH_MOD_END;
            end else begin
               size_emit = SIZE_H;
               emit      = 1'b1;
            end
         end
         PH_MOD_L: begin
            if (ch == CH_LOWER_L) begin
               flags_next.size_code = SIZE_LL;
               phase_next           = PH_MOD_END;
            end else begin
               size_emit = SIZE_L;
               emit      = 1'b1;
            end
         end
         PH_MOD_END: begin
            emit = 1'b1;
         end
         default: begin
            phase_next = PH_IDLE;
         end
      endcase

      // A character that does not continue the number may start a length
      // modifier; anything else is the conversion character.
      if (try_mod) begin
         if (ch == CH_LOWER_H) begin
            phase_next = PH_MOD_H;
         end else if (ch == CH_LOWER_L) begin
            phase_next = PH_MOD_L;
         end else if (ch == CH_UPPER_L) begin
            flags_next.size_code = SIZE_LL;
            phase_next           = PH_MOD_END;
         end else begin
            emit = 1'b1;
         end
      end

      // A finished specifier clears all fields and returns to idle.
      if (emit) begin
         flags_next     = FLAGS_CLEAR;
         width_acc_next = '0;
         prec_acc_next  = '0;
         phase_next     = PH_IDLE;
      end
   end

   // Result fields come from the state before this character; the conversion character is this character itself.
   always_comb begin
      result.alt_form        = flags.alt_seen;
      result.left_adjust     = flags.left_seen;
      result.sign_mode       = flags.sign_kind;
      result.zero_pad        = flags.zero_seen & ~flags.left_seen;
      result.width           = NUM_BITS'(width_acc);
      result.width_given     = flags.width_flag;
      result.precision       = NUM_BITS'(prec_acc);
      result.precision_given = flags.prec_flag;
      result.int_size        = size_emit;
      result.conv_char       = ch;
   end

endmodule

>>> sv/printf_spec_parser.sv
// ----------------------------------------------------------------------------
// printf_spec_parser: streaming parser for printf conversion specifiers
// Reads format text one character per transfer and reports each specifier.
// ----------------------------------------------------------------------------
// The parser takes one character per clock cycle unless the input register
// stalls. A character is captured in an input register, and the parse step
// runs on it in the following cycle. A completed specifier is loaded into
// the result register when that character advances, so its result passes
// through the input register and then the result register. The input register
// only stalls when a character would end a specifier while the result register
// still holds an untaken result.
// Characters outside a specifier are dropped until a '%'. Width and precision
// saturate at 2^COUNT_BITS-1 and are reported in their low 16 bits.
module printf_spec_parser
   import spf_pkg::*;
#(
   parameter int COUNT_BITS = SPF_COUNT_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CHAR_BITS-1:0] req_ch,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_alt_form,
   output logic                 rsp_left_adjust,
   output logic [SIGN_BITS-1:0] rsp_sign_mode,
   output logic                 rsp_zero_pad,
   output logic [NUM_BITS-1:0]  rsp_width,
   output logic                 rsp_width_given,
   output logic [NUM_BITS-1:0]  rsp_precision,
   output logic                 rsp_precision_given,
   output logic [SIZE_BITS-1:0] rsp_int_size,
   output logic [CHAR_BITS-1:0] rsp_conv_char
);

   logic                  in_valid_ff, in_valid_in;
   logic [CHAR_BITS-1:0]  in_ch_ff;
   phase_type             phase_ff, phase_in;
   flags_type             flags_ff, flags_in;
   logic [COUNT_BITS-1:0] width_acc_ff, width_acc_in;
   logic [COUNT_BITS-1:0] prec_acc_ff, prec_acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            result_ff, step_result;
   logic                  step_emit;
   logic                  advance;

   // Parse step on the registered character.
   spf_step #(
      .COUNT_BITS(COUNT_BITS)
   ) u_step (
      .phase          (phase_ff),
      .flags          (flags_ff),
      .width_acc      (width_acc_ff),
      .prec_acc       (prec_acc_ff),
      .ch             (in_ch_ff),
      .phase_next     (phase_in),
      .flags_next     (flags_in),
      .width_acc_next (width_acc_in),
      .prec_acc_next  (prec_acc_in),
      .emit           (step_emit),
      .result         (step_result)
   );

   // The held character is consumed unless its result has nowhere to go.
   assign advance   = in_valid_ff && (!step_emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance && step_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and parse state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         flags_ff     <= FLAGS_CLEAR;
         width_acc_ff <= '0;
         prec_acc_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff     <= phase_in;
            flags_ff     <= flags_in;
            width_acc_ff <= width_acc_in;
            prec_acc_ff  <= prec_acc_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff <= req_ch;
      end
      if (advance && step_emit) begin
         result_ff <= step_result;
      end
   end

   // Result port.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_alt_form        = result_ff.alt_form;
   assign rsp_left_adjust     = result_ff.left_adjust;
   assign rsp_sign_mode       = result_ff.sign_mode;
   assign rsp_zero_pad        = result_ff.zero_pad;
   assign rsp_width           = result_ff.width;
   assign rsp_width_given     = result_ff.width_given;
   assign rsp_precision       = result_ff.precision;
   assign rsp_precision_given = result_ff.precision_given;
   assign rsp_int_size        = result_ff.int_size;
   assign rsp_conv_char       = result_ff.conv_char;

endmodule
